// File: hw/rtl/blrc_pkg.sv
// shared types, constants and codes for the button lockout / repeat / chord block
package blrc_pkg;

    localparam int BTN_W           = 16;
    localparam int CNT_W           = 8;
    localparam int REPEAT_W        = 9;
    localparam int TIMER_W         = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int NUM_BUTTONS_DEF = 16;

    localparam int CHORD_A_BIT = 11;
    localparam int CHORD_B_BIT = 10;

    localparam logic [REPEAT_W-1:0] REPEAT_MAX   = 9'd511;
    localparam logic [TIMER_W-1:0]  TIMER_MAX    = 3'd7;
    localparam logic [TIMER_W-1:0]  CHORD_WINDOW = 3'd4;

    localparam logic [7:0]  RST_REPEAT_DELAY    = 8'd10;
    localparam logic [7:0]  RST_REPEAT_INTERVAL = 8'd4;
    localparam logic [15:0] RST_LOCKOUT_MASK    = 16'h0C00;
    localparam logic [7:0]  RST_LOCKOUT_TICKS   = 8'd6;

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_WAIT_A = 2'd1;
    localparam logic [1:0] PHASE_WAIT_B = 2'd2;
    localparam logic [1:0] PHASE_CHORD  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_DELAY    = 2'd0,
        CFG_REPEAT_INTERVAL = 2'd1,
        CFG_LOCKOUT_MASK    = 2'd2,
        CFG_LOCKOUT_TICKS   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        CH_IDLE   = 4'b0001,
        CH_WAIT_A = 4'b0010,
        CH_WAIT_B = 4'b0100,
        CH_CHORD  = 4'b1000
    } chord_state_t;

    typedef struct packed {
        logic [BTN_W-1:0] held;
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] released;
    } btn_masks_t;

    typedef struct packed {
        logic       active;
        logic       was_active;
        logic [1:0] phase;
    } chord_status_t;

endpackage

// File: hw/rtl/blrc_if.sv
// valid/ready channel interfaces for frame items and result items
interface blrc_in_if;
    logic                       valid;
    logic                       ready;
    logic [blrc_pkg::BTN_W-1:0] raw_buttons;
    logic                       freeze;

    modport source (output valid, output raw_buttons, output freeze, input ready);
    modport sink   (input valid, input raw_buttons, input freeze, output ready);
endinterface

interface blrc_out_if;
    logic                       valid;
    logic                       ready;
    logic [blrc_pkg::BTN_W-1:0] held_mask;
    logic [blrc_pkg::BTN_W-1:0] pressed_mask;
    logic [blrc_pkg::BTN_W-1:0] released_mask;
    logic [blrc_pkg::BTN_W-1:0] repeat_mask;
    logic                       chord_active;
    logic                       chord_was_active;
    logic [1:0]                 chord_phase;

    modport source (output valid, output held_mask, output pressed_mask,
                    output released_mask, output repeat_mask, output chord_active,
                    output chord_was_active, output chord_phase, input ready);
    modport sink   (input valid, input held_mask, input pressed_mask,
                    input released_mask, input repeat_mask, input chord_active,
                    input chord_was_active, input chord_phase, output ready);
endinterface

// File: hw/rtl/blrc_lockout.sv
// per-button lockout counters and filtered held / pressed / released masks
module blrc_lockout #(
    parameter int NUM_BUTTONS = blrc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [blrc_pkg::BTN_W-1:0] raw_buttons,
    input  logic                       freeze,
    input  logic [blrc_pkg::BTN_W-1:0] lockout_mask,
    input  logic [blrc_pkg::CNT_W-1:0] lockout_ticks,
    output logic [blrc_pkg::BTN_W-1:0] prev_held,
    output blrc_pkg::btn_masks_t       masks
);
    import blrc_pkg::*;

    // buttons beyond the 16-bit input never see a raw bit, so they stay inert
    localparam int LIVE_BTNS = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

    logic [CNT_W-1:0] cnt_reg  [LIVE_BTNS];
    logic [CNT_W-1:0] cnt_next [LIVE_BTNS];
    logic [BTN_W-1:0] prev_held_reg;
    logic [BTN_W-1:0] held_v;
    logic [BTN_W-1:0] pressed_v;
    logic [BTN_W-1:0] released_v;

    for (genvar i = 0; i < LIVE_BTNS; i++) begin : g_btn
        logic cnt_zero;

        assign cnt_zero      = (cnt_reg[i] == '0);
        assign held_v[i]     = cnt_zero & raw_buttons[i];
        assign pressed_v[i]  = cnt_zero & raw_buttons[i] & ~prev_held_reg[i];
        assign released_v[i] = cnt_zero & ~raw_buttons[i] & prev_held_reg[i];

        always_comb
        begin
            cnt_next[i] = cnt_reg[i];
            if (!cnt_zero)
            begin
                if (!freeze)
                begin
                    // still down when the count runs out: hold at one
                    if (cnt_reg[i] == CNT_W'(1) && raw_buttons[i])
                        cnt_next[i] = CNT_W'(1);
                    else
                        cnt_next[i] = cnt_reg[i] - CNT_W'(1);
                end
            end
            else if (released_v[i] && !freeze)
            begin
                cnt_next[i] = lockout_mask[i] ? lockout_ticks : '0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cnt_reg[i] <= '0;
            else if (step)
                cnt_reg[i] <= cnt_next[i];
        end
    end

    for (genvar j = LIVE_BTNS; j < BTN_W; j++) begin : g_dead
        assign held_v[j]     = 1'b0;
        assign pressed_v[j]  = 1'b0;
        assign released_v[j] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_held_reg <= '0;
        else if (step)
            prev_held_reg <= held_v;
    end

    assign prev_held      = prev_held_reg;
    assign masks.held     = held_v;
    assign masks.pressed  = pressed_v;
    assign masks.released = released_v;

endmodule

// File: hw/rtl/blrc_repeat.sv
// typematic repeat counter with saturating count
module blrc_repeat (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [blrc_pkg::BTN_W-1:0] held,
    input  logic [blrc_pkg::BTN_W-1:0] prev_held,
    input  logic                       pressed_any,
    input  logic [7:0]                 repeat_delay,
    input  logic [7:0]                 repeat_interval,
    output logic [blrc_pkg::BTN_W-1:0] repeat_mask
);
    import blrc_pkg::*;

    logic [REPEAT_W-1:0] count_reg;
    logic [REPEAT_W-1:0] count_next;
    logic [REPEAT_W-1:0] count_base;
    logic [REPEAT_W-1:0] count_inc;
    logic [REPEAT_W-1:0] delay_ext;
    logic [REPEAT_W-1:0] second_hit;
    logic                fire;

    assign delay_ext  = {1'b0, repeat_delay};
    assign second_hit = delay_ext + {1'b0, repeat_interval};
    assign count_base = pressed_any ? '0 : count_reg;
    assign count_inc  = (count_base == REPEAT_MAX) ? count_base
                                                   : count_base + REPEAT_W'(1);

    always_comb
    begin
        fire       = 1'b0;
        count_next = count_base;
        if (prev_held == held)
        begin
            count_next = count_inc;
            if (count_inc == delay_ext || count_inc == second_hit)
            begin
                fire       = 1'b1;
                count_next = delay_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (step)
            count_reg <= count_next;
    end

    assign repeat_mask = fire ? held : '0;

endmodule

// File: hw/rtl/blrc_chord.sv
// two-button chord state machine with a four-frame window
module blrc_chord (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    press_a,
    input  logic                    press_b,
    input  logic                    release_a,
    input  logic                    release_b,
    output blrc_pkg::chord_status_t status
);
    import blrc_pkg::*;

    chord_state_t       state_reg;
    chord_state_t       state_next;
    logic               flag_reg;
    logic               flag_next;
    logic               was_active;
    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic [TIMER_W-1:0] timer_tick;
    logic [1:0]         phase_out;

    assign timer_tick = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + TIMER_W'(1);

    always_comb
    begin
        state_next = state_reg;
        flag_next  = flag_reg;
        timer_next = timer_reg;
        was_active = flag_reg;
        if (!flag_reg)
        begin
            case (state_reg)
                CH_WAIT_A, CH_WAIT_B:
                begin
                    timer_next = timer_tick;
                    if (timer_tick >= CHORD_WINDOW)
                        state_next = CH_IDLE;
                    else if (press_a || press_b)
                    begin
                        state_next = CH_CHORD;
                        flag_next  = 1'b1;
                    end
                end
                CH_IDLE:
                begin
                    if (press_a && press_b)
                    begin
                        state_next = CH_CHORD;
                        flag_next  = 1'b1;
                    end
                    else if (press_a)
                    begin
                        state_next = CH_WAIT_A;
                        timer_next = '0;
                    end
                    else if (press_b)
                    begin
                        state_next = CH_WAIT_B;
                        timer_next = '0;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            case (state_reg)
                CH_WAIT_A, CH_WAIT_B:
                begin
                    timer_next = timer_tick;
                    if (timer_tick >= CHORD_WINDOW)
                    begin
                        // timeout also drops the start-of-frame flag
                        state_next = CH_IDLE;
                        flag_next  = 1'b0;
                        was_active = 1'b0;
                    end
                    else if (release_a || release_b)
                    begin
                        state_next = CH_IDLE;
                        flag_next  = 1'b0;
                    end
                end
                CH_CHORD:
                begin
                    if (release_a && release_b)
                    begin
                        state_next = CH_IDLE;
                        flag_next  = 1'b0;
                    end
                    else if (release_a)
                    begin
                        state_next = CH_WAIT_B;
                        timer_next = '0;
                    end
                    else if (release_b)
                    begin
                        state_next = CH_WAIT_A;
                        timer_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CH_IDLE;
            flag_reg  <= 1'b0;
            timer_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            flag_reg  <= flag_next;
            timer_reg <= timer_next;
        end
    end

    always_comb
    begin
        case (state_next)
            CH_IDLE:   phase_out = PHASE_IDLE;
            CH_WAIT_A: phase_out = PHASE_WAIT_A;
            CH_WAIT_B: phase_out = PHASE_WAIT_B;
            CH_CHORD:  phase_out = PHASE_CHORD;
            default:   phase_out = PHASE_IDLE;
        endcase
    end

    assign status.phase      = phase_out;
    assign status.active     = flag_next;
    assign status.was_active = was_active;

`ifndef SYNTHESIS
    a_chord_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CH_CHORD) |-> flag_reg)
        else $error("chord phase without chord flag");
    a_flag_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |-> (state_reg != CH_IDLE))
        else $error("chord flag set while idle");
`endif

endmodule

// File: hw/rtl/button_lockout_repeat_chord.sv
// top level: button lockout filter with typematic repeat and chord tracking
// path: an accepted item passes through the input register, then the result register
// throughput: one item per cycle unless the result is stalled; the frame update is one pass of per-button logic
// input and result registers decouple the two channels, so a stalled result still
//   lets one more item in
// reset: async active low; counters, history, chord state and valids cleared, config to defaults
module button_lockout_repeat_chord #(
    parameter int NUM_BUTTONS = blrc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    blrc_in_if.sink                         frame_in,
    blrc_out_if.source                      frame_out,
    input  logic                            cfg_we,
    input  logic [blrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blrc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import blrc_pkg::*;

    // configuration registers
    logic [7:0]       repeat_delay_reg;
    logic [7:0]       repeat_interval_reg;
    logic [BTN_W-1:0] lockout_mask_reg;
    logic [CNT_W-1:0] lockout_ticks_reg;

    // input stage
    logic             in_valid_reg;
    logic [BTN_W-1:0] raw_reg;
    logic             freeze_reg;

    // result stage
    logic             out_valid_reg;
    btn_masks_t       masks_reg;
    logic [BTN_W-1:0] repeat_reg;
    chord_status_t    chord_reg;

    // datapath between the two stages
    logic             step;
    logic [BTN_W-1:0] prev_held;
    btn_masks_t       masks;
    logic [BTN_W-1:0] repeat_mask;
    chord_status_t    chord;

    // one frame moves from the input register into the result register
    assign step           = in_valid_reg && (!out_valid_reg || frame_out.ready);
    assign frame_in.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_delay_reg    <= RST_REPEAT_DELAY;
            repeat_interval_reg <= RST_REPEAT_INTERVAL;
            lockout_mask_reg    <= RST_LOCKOUT_MASK;
            lockout_ticks_reg   <= RST_LOCKOUT_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_data[7:0];
                CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data[7:0];
                CFG_LOCKOUT_MASK:    lockout_mask_reg    <= cfg_data[BTN_W-1:0];
                CFG_LOCKOUT_TICKS:   lockout_ticks_reg   <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register: refilled whenever it is empty or draining this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (frame_in.valid && frame_in.ready)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            raw_reg    <= frame_in.raw_buttons;
            freeze_reg <= frame_in.freeze;
        end
    end

    blrc_lockout #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_lockout (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .raw_buttons   (raw_reg),
        .freeze        (freeze_reg),
        .lockout_mask  (lockout_mask_reg),
        .lockout_ticks (lockout_ticks_reg),
        .prev_held     (prev_held),
        .masks         (masks)
    );

    blrc_repeat u_repeat (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .held            (masks.held),
        .prev_held       (prev_held),
        .pressed_any     (|masks.pressed),
        .repeat_delay    (repeat_delay_reg),
        .repeat_interval (repeat_interval_reg),
        .repeat_mask     (repeat_mask)
    );

    // chord buttons are bits 11 and 10
    blrc_chord u_chord (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .press_a   (masks.pressed[CHORD_A_BIT]),
        .press_b   (masks.pressed[CHORD_B_BIT]),
        .release_a (masks.released[CHORD_A_BIT]),
        .release_b (masks.released[CHORD_B_BIT]),
        .status    (chord)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (frame_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            masks_reg  <= masks;
            repeat_reg <= repeat_mask;
            chord_reg  <= chord;
        end
    end

    assign frame_out.valid            = out_valid_reg;
    assign frame_out.held_mask        = masks_reg.held;
    assign frame_out.pressed_mask     = masks_reg.pressed;
    assign frame_out.released_mask    = masks_reg.released;
    assign frame_out.repeat_mask      = repeat_reg;
    assign frame_out.chord_active     = chord_reg.active;
    assign frame_out.chord_was_active = chord_reg.was_active;
    assign frame_out.chord_phase      = chord_reg.phase;

`ifndef SYNTHESIS
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result appeared without a frame update");
    a_full_input_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |-> !frame_in.ready)
        else $error("input taken while input register held an item");
`endif

endmodule
